// ===== design/frd_pkg.sv =====
package frd_pkg;

    localparam int COORD_BITS = 24;
    localparam int CNT_BITS   = 11;
    localparam int RMS_BITS   = 24;
    localparam int FRAME_BITS = 16;
    localparam int TOTAL_BITS = 64;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS  = TOTAL_BITS / 2;
    localparam int SREM_BITS  = ROOT_BITS + 2;
    localparam int DIV_STEPS  = TOTAL_BITS;
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int ITER_BITS  = $clog2(DIV_STEPS);

    localparam logic [RMS_BITS-1:0]   RMS_MAX   = '1;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
    localparam logic [CNT_BITS-1:0]   CNT_RESET = CNT_BITS'(1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic                         start_over;
    } frd_in_t;

    typedef struct packed {
        logic [RMS_BITS-1:0]   rms_value;
        logic [FRAME_BITS-1:0] frame_number;
    } frd_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SQUARE,
        OP_ACCUM,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_EMIT
    } frd_op_t;

    typedef struct packed {
        frd_op_t op;
    } frd_cmd_t;

    typedef struct packed {
        logic compare;   // incoming word is compared against the reference
        logic last;      // word under compare closes its frame
        logic out_free;  // output register can take a result this cycle
    } frd_sts_t;

endpackage

// ===== design/frd_ram.sv =====
module frd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/frd_ctrl.sv =====
module frd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  frd_pkg::frd_sts_t sts,
    output frd_pkg::frd_cmd_t cmd
);
    import frd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [ITER_BITS-1:0]   iter_reg, iter_next;
    logic                   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op = OP_ACCEPT;
                    if (sts.compare) begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                cmd.op     = OP_SQUARE;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.op = OP_ACCUM;
                if (sts.last) begin
                    state_next = ST_DIV;
                    iter_next  = '0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.op    = OP_DIV_STEP;
                iter_next = iter_reg + ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                iter_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op    = OP_SQRT_STEP;
                iter_next = iter_reg + ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(SQRT_STEPS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // a reference word finishes in its accept cycle
    a_ref_word_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !sts.compare |=> s_ready)
        else $error("reference word did not finish in one cycle");

    // the divider always starts from step zero
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACCUM && sts.last |=> state_reg == ST_DIV && iter_reg == '0)
        else $error("divider entered with stale step count");

    // emit only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> sts.out_free)
        else $error("result emitted over a pending one");

    // nothing is taken in while a frame end is being worked out
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV || state_reg == ST_SQRT |-> !s_ready)
        else $error("input taken during divide or root");

endmodule

// ===== design/frd_dpath.sv =====
module frd_dpath #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [frd_pkg::CNT_BITS-1:0]   cfg_wdata,
    input  frd_pkg::frd_in_t               s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output frd_pkg::frd_out_t              m_word,
    input  frd_pkg::frd_cmd_t              cmd,
    output frd_pkg::frd_sts_t              sts
);
    import frd_pkg::*;

    localparam int PW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int EW = ((CW > CNT_BITS) ? CW : CNT_BITS) + 1;
    localparam int DW = EW + 2;
    localparam int RW = 3 * COORD_BITS;

    // control state
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic                  ref_ready_reg, ref_ready_next;
    logic [FRAME_BITS-1:0] frames_reg, frames_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  last_reg, last_next;

    // payload
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [SQ_BITS-1:0]    sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic [TOTAL_BITS-1:0] quo_reg, quo_next;
    logic [DW-1:0]         drem_reg, drem_next;
    logic [DW-1:0]         divisor_reg, divisor_next;
    logic [SREM_BITS-1:0]  srem_reg, srem_next;
    logic [ROOT_BITS-1:0]  root_reg, root_next;
    frd_out_t              out_reg, out_next;

    // frame position and count
    logic [EW-1:0] cnt_wide, cnt_eff, pos_plus;
    logic [PW-1:0] pos_eff;
    logic          at_last, compare;

    // memory
    logic          ram_we, ram_re;
    logic [RW-1:0] ram_rdata;

    // arithmetic
    logic signed [COORD_BITS:0]   dx, dy, dz;
    logic signed [2*COORD_BITS+1:0] px, py, pz;
    logic [SQ_BITS+1:0]    sq_sum;
    logic [TOTAL_BITS:0]   acc_sum;
    logic [TOTAL_BITS-1:0] acc_sat;
    logic [DW:0]           drem_shift;
    logic                  dbit;
    logic [SREM_BITS+1:0]  srem_shift, strial;
    logic                  sbit;
    logic [RMS_BITS-1:0]   rms_sat;

    always_comb begin
        cnt_wide = EW'(cnt_reg);
        if (cnt_wide == '0) begin
            cnt_eff = EW'(1);
        end else if (cnt_wide > EW'(MAX_ATOMS)) begin
            cnt_eff = EW'(MAX_ATOMS);
        end else begin
            cnt_eff = cnt_wide;
        end
    end

    assign compare  = ref_ready_reg && !s_word.start_over;
    assign pos_eff  = s_word.start_over ? '0 : pos_reg;
    assign pos_plus = EW'(pos_eff) + EW'(1);
    assign at_last  = (pos_plus >= cnt_eff);

    assign ram_we = (cmd.op == OP_ACCEPT) && !compare;
    assign ram_re = (cmd.op == OP_ACCEPT) && compare;

    frd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ATOMS)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_eff),
        .wdata ({s_word.coord_x, s_word.coord_y, s_word.coord_z}),
        .re    (ram_re),
        .raddr (pos_eff),
        .rdata (ram_rdata)
    );

    // exact differences, one square per axis
    assign dx = {x_reg[COORD_BITS-1], x_reg}
              - {ram_rdata[3*COORD_BITS-1], ram_rdata[3*COORD_BITS-1:2*COORD_BITS]};
    assign dy = {y_reg[COORD_BITS-1], y_reg}
              - {ram_rdata[2*COORD_BITS-1], ram_rdata[2*COORD_BITS-1:COORD_BITS]};
    assign dz = {z_reg[COORD_BITS-1], z_reg}
              - {ram_rdata[COORD_BITS-1], ram_rdata[COORD_BITS-1:0]};
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    // saturating accumulate
    assign sq_sum  = (SQ_BITS+2)'(sqx_reg) + (SQ_BITS+2)'(sqy_reg) + (SQ_BITS+2)'(sqz_reg);
    assign acc_sum = {1'b0, total_reg} + (TOTAL_BITS+1)'(sq_sum);
    assign acc_sat = acc_sum[TOTAL_BITS] ? '1 : acc_sum[TOTAL_BITS-1:0];

    // restoring divide, one quotient bit per step
    assign drem_shift = {drem_reg, quo_reg[TOTAL_BITS-1]};
    assign dbit       = (drem_shift >= {1'b0, divisor_reg});

    // digit-by-digit square root, two radicand bits per step
    assign srem_shift = {srem_reg, quo_reg[TOTAL_BITS-1:TOTAL_BITS-2]};
    assign strial     = (SREM_BITS+2)'({root_reg, 2'b01});
    assign sbit       = (srem_shift >= strial);

    assign rms_sat = (root_reg > ROOT_BITS'(RMS_MAX)) ? RMS_MAX : root_reg[RMS_BITS-1:0];

    always_comb begin
        cnt_next       = cfg_we ? cfg_wdata : cnt_reg;
        pos_next       = pos_reg;
        ref_ready_next = ref_ready_reg;
        frames_next    = frames_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        last_next      = last_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        sqz_next       = sqz_reg;
        quo_next       = quo_reg;
        drem_next      = drem_reg;
        divisor_next   = divisor_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        out_next       = out_reg;
        unique case (cmd.op)
            OP_ACCEPT: begin
                if (s_word.start_over) begin
                    frames_next = '0;
                end
                x_next    = s_word.coord_x;
                y_next    = s_word.coord_y;
                z_next    = s_word.coord_z;
                last_next = at_last;
                if (!compare) begin
                    ref_ready_next = at_last;
                    if (at_last) begin
                        pos_next   = '0;
                        total_next = '0;
                    end else begin
                        pos_next = PW'(pos_plus);
                    end
                end
            end
            OP_SQUARE: begin
                sqx_next = px[SQ_BITS-1:0];
                sqy_next = py[SQ_BITS-1:0];
                sqz_next = pz[SQ_BITS-1:0];
            end
            OP_ACCUM: begin
                if (last_reg) begin
                    quo_next     = acc_sat;
                    drem_next    = '0;
                    divisor_next = (DW'(cnt_eff) << 1) + DW'(cnt_eff);
                    total_next   = '0;
                    pos_next     = '0;
                end else begin
                    total_next = acc_sat;
                    pos_next   = pos_reg + PW'(1);
                end
            end
            OP_DIV_STEP: begin
                drem_next = dbit ? DW'(drem_shift - {1'b0, divisor_reg}) : drem_shift[DW-1:0];
                quo_next  = {quo_reg[TOTAL_BITS-2:0], dbit};
            end
            OP_SQRT_INIT: begin
                srem_next = '0;
                root_next = '0;
            end
            OP_SQRT_STEP: begin
                srem_next = sbit ? SREM_BITS'(srem_shift - strial)
                                 : srem_shift[SREM_BITS-1:0];
                root_next = {root_reg[ROOT_BITS-2:0], sbit};
                quo_next  = {quo_reg[TOTAL_BITS-3:0], 2'b00};
            end
            OP_EMIT: begin
                frames_next           = (frames_reg == FRAME_MAX) ? FRAME_BITS'(1)
                                                                 : frames_reg + FRAME_BITS'(1);
                out_next.rms_value    = rms_sat;
                out_next.frame_number = frames_next;
                m_valid_next          = 1'b1;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= CNT_RESET;
            pos_reg       <= '0;
            ref_ready_reg <= 1'b0;
            frames_reg    <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            ref_ready_reg <= ref_ready_next;
            frames_reg    <= frames_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sqz_reg     <= sqz_next;
        quo_reg     <= quo_next;
        drem_reg    <= drem_next;
        divisor_reg <= divisor_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        out_reg     <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_word       = out_reg;
    assign sts.compare  = compare;
    assign sts.last     = last_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    // the frame position stays inside the reference store
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(pos_reg) < MAX_ATOMS)
        else $error("frame position beyond reference store");

    // a frame end clears the running sum and position
    a_frame_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_ACCUM && last_reg |=> total_reg == '0 && pos_reg == '0)
        else $error("sum or position not cleared at frame end");

    // a result carries a nonzero frame number
    a_frame_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |=> m_valid && m_word.frame_number != '0)
        else $error("result emitted with frame number zero");

endmodule

// ===== design/frame_rms_displacement.sv =====
// Channel   Ports                          Direction  Payload
// input     s_valid, s_ready, s_word       in         frd_in_t: coord_x/y/z, start_over
// result    m_valid, m_ready, m_word       out        frd_out_t: rms_value, frame_number
// config    cfg_we, cfg_wdata              in         atom_count, 11 bits, no wait state
//
// A reference word (first frame after reset or after start_over) is stored as it is
// accepted, and the block stays ready. A compared word goes through accept with
// reference read, square and accumulate; the last word of a compared frame then
// adds a divide, a square root and an emit, run by the bit-serial divider and root unit.
// Reset is synchronous on aresetn low; the reference store needs no clearing pass.
// A result waits in the output register while the next word is taken; only a
// second frame end stalls (in emit) until the previous result has gone.
module frame_rms_displacement #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [frd_pkg::CNT_BITS-1:0] cfg_wdata,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  frd_pkg::frd_in_t             s_word,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output frd_pkg::frd_out_t            m_word
);
    import frd_pkg::*;

    frd_cmd_t cmd;
    frd_sts_t sts;

    // sequence each word: accept, then for compared words square and accumulate, and divide, root and emit at frame end
    frd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold reference store, running sum, divider, root unit and output register
    frd_dpath #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== test/frd_rms_checker.sv =====
`timescale 1ns / 100ps

module frd_rms_checker #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [frd_pkg::CNT_BITS-1:0] cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  frd_pkg::frd_in_t             s_word,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  frd_pkg::frd_out_t            m_word,
    input  logic                         run_done,
    output int                           fail_count,
    output int                           pending_words,
    output int                           results_seen
);
    import frd_pkg::*;

    localparam int SHOWN_MAX = 10;

    logic signed [COORD_BITS-1:0] ref_x [MAX_ATOMS];
    logic signed [COORD_BITS-1:0] ref_y [MAX_ATOMS];
    logic signed [COORD_BITS-1:0] ref_z [MAX_ATOMS];
    int unsigned                  atom_pos;
    logic [TOTAL_BITS-1:0]        sq_total;
    logic                         ref_loaded;
    logic [FRAME_BITS-1:0]        frame_cnt;
    logic [CNT_BITS-1:0]          atom_count;
    frd_out_t                     rms_due [$];
    frd_out_t                     want;
    int                           error_total = 0;
    int                           result_total = 0;
    logic                         leftover_done = 1'b0;

    function automatic logic [TOTAL_BITS-1:0] sq_of_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        longint      d;
        logic [63:0] m;
        d = longint'(a) - longint'(b);
        m = (d < 0) ? -d : d;
        if (m > 64'hFFFF_FFFF)
            return {TOTAL_BITS{1'b1}};
        return m * m;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] add_clamped(
        input logic [TOTAL_BITS-1:0] a,
        input logic [TOTAL_BITS-1:0] b
    );
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
    endfunction

    // bit-pair integer square root, floor
    function automatic logic [TOTAL_BITS-1:0] root_floor(input logic [TOTAL_BITS-1:0] v);
        logic [TOTAL_BITS-1:0] rem;
        logic [TOTAL_BITS-1:0] res;
        logic [TOTAL_BITS-1:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < ROOT_BITS; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned atoms_per_frame();
        int unsigned c;
        c = atom_count;
        if (c == 0)
            c = 1;
        if (c > MAX_ATOMS)
            c = MAX_ATOMS;
        return c;
    endfunction

    task automatic fold_atom(input frd_in_t w);
        int unsigned           eff;
        int unsigned           pos;
        logic                  last;
        logic [TOTAL_BITS-1:0] mean;
        logic [TOTAL_BITS-1:0] root;
        frd_out_t              res;
        eff = atoms_per_frame();
        if (w.start_over) begin
            atom_pos   = 0;
            sq_total   = '0;
            ref_loaded = 1'b0;
            frame_cnt  = '0;
        end
        pos  = (atom_pos >= MAX_ATOMS) ? MAX_ATOMS - 1 : atom_pos;
        last = (pos + 1 >= eff);
        if (!ref_loaded) begin
            ref_x[pos] = w.coord_x;
            ref_y[pos] = w.coord_y;
            ref_z[pos] = w.coord_z;
            if (last) begin
                ref_loaded = 1'b1;
                atom_pos   = 0;
                sq_total   = '0;
            end else begin
                atom_pos = pos + 1;
            end
        end else begin
            sq_total = add_clamped(sq_total, sq_of_diff(w.coord_x, ref_x[pos]));
            sq_total = add_clamped(sq_total, sq_of_diff(w.coord_y, ref_y[pos]));
            sq_total = add_clamped(sq_total, sq_of_diff(w.coord_z, ref_z[pos]));
            if (!last) begin
                atom_pos = pos + 1;
            end else begin
                mean          = sq_total / TOTAL_BITS'(3 * eff);
                root          = root_floor(mean);
                res.rms_value = (root > RMS_MAX) ? RMS_MAX : root[RMS_BITS-1:0];
                frame_cnt     = (frame_cnt == FRAME_MAX) ? FRAME_BITS'(1) : frame_cnt + 1'b1;
                res.frame_number = frame_cnt;
                rms_due = {rms_due, res};
                atom_pos = 0;
                sq_total = '0;
            end
        end
    endtask

    task automatic flag(input string msg);
        if (error_total < SHOWN_MAX)
            $display("%0t: %s", $time, msg);
        error_total++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            atom_pos   = 0;
            sq_total   = '0;
            ref_loaded = 1'b0;
            frame_cnt  = '0;
            atom_count = CNT_RESET;
            rms_due.delete();
        end else begin
            if (cfg_we)
                atom_count = cfg_wdata;
            // retire before predicting: a word taken at this edge cannot have a result yet
            if (m_valid && m_ready) begin
                result_total++;
                if (rms_due.size() == 0) begin
                    flag($sformatf("result with none due: rms %h frame %0d",
                                   m_word.rms_value, m_word.frame_number));
                end else begin
                    want = rms_due.pop_front();
                    if (m_word.rms_value !== want.rms_value ||
                        m_word.frame_number !== want.frame_number)
                        flag($sformatf("expected rms %h frame %0d, got rms %h frame %0d",
                                       want.rms_value, want.frame_number,
                                       m_word.rms_value, m_word.frame_number));
                end
            end
            if (s_valid && s_ready)
                fold_atom(s_word);
            if (run_done && !leftover_done) begin
                leftover_done = 1'b1;
                if (rms_due.size() != 0)
                    flag($sformatf("%0d results never arrived", rms_due.size()));
            end
        end
        fail_count    <= error_total;
        pending_words <= rms_due.size();
        results_seen  <= result_total;
    end

endmodule

// ===== test/frame_rms_displacement_test.sv =====
`timescale 1ns / 100ps

module frame_rms_displacement_test;
    import frd_pkg::*;

    localparam int MAX_ATOMS   = 1024;
    localparam int ITEM_TARGET = 1750;
    // a frame end runs divide, root and emit; leave room for it
    localparam int SETTLE      = 200;
    localparam int HOLD_LEN    = 600;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {STYLE_NEAR, STYLE_DRIFT, STYLE_WILD, STYLE_EDGE} coord_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CNT_BITS-1:0]   cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    frd_in_t               s_word;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    frd_out_t              m_word;
    logic                  run_done;
    int                    fail_count;
    int                    pending_words;
    int                    results_seen;

    idle_mode_t            idle_mode = IDLE_NONE;
    int                    hold_asks = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;
    int                    words_sent = 0;
    int                    settings_used = 0;
    int                    cycles_run = 0;
    frd_in_t               base_atom [MAX_ATOMS];

    frame_rms_displacement #(
        .MAX_ATOMS (MAX_ATOMS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    frd_rms_checker #(
        .MAX_ATOMS (MAX_ATOMS)
    ) rms_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .results_seen  (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: count cycles and give up far beyond the slowest legal run.
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("Run stopped after %0d cycles without finishing", cycles_run);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 62;
            IDLE_BOTH:   return $urandom_range(0, 99) < 6;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_rests();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 62;
            IDLE_BOTH:     return $urandom_range(0, 99) < 6;
            default:       return 1'b0;
        endcase
    endfunction

    // Receiver: a hold-off request blocks m_ready until a countdown from HOLD_LEN, kept here, runs out;
    // otherwise stall at random per the current idle mode.
    always @(posedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !receiver_rests();
        end
    end

    function automatic frd_in_t pack_atom(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] z,
        input logic                         so
    );
        frd_in_t w;
        w.coord_x    = x;
        w.coord_y    = y;
        w.coord_z    = z;
        w.start_over = so;
        return w;
    endfunction

    // Coordinate for a compared atom: near or drifting around its reference value, else wild or edge.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(
        input coord_style_t                 style,
        input logic signed [COORD_BITS-1:0] base
    );
        case (style)
            STYLE_NEAR:  return base + COORD_BITS'($urandom_range(0, 511)) - 24'sd256;
            STYLE_DRIFT: return base + COORD_BITS'($urandom_range(0, 131071)) - 24'sd65536;
            STYLE_WILD:  return COORD_BITS'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Reference coordinate: half full range, half within +-8 angstrom.
    function automatic logic signed [COORD_BITS-1:0] ref_coord();
        if ($urandom_range(0, 1))
            return COORD_BITS'($urandom);
        return COORD_BITS'($urandom_range(0, 1 << 20)) - 24'sd524288;
    endfunction

    function automatic int atoms_in(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_ATOMS)
            return MAX_ATOMS;
        return v;
    endfunction

    // Offer one word and hold it until taken. Valid is only lowered inside a gap,
    // so back-to-back words never see a low and a high in the same step.
    task automatic send_word(input frd_in_t w);
        while (sender_rests()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
    endtask

    // Drop valid and hold until every predicted result has been retired.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_words != 0);
    endtask

    // Words that end no frame may still be in flight; let them settle too.
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_count(input int v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_BITS'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_reference(input int atoms);
        frd_in_t w;
        for (int a = 0; a < atoms; a++) begin
            w = pack_atom(ref_coord(), ref_coord(), ref_coord(), a == 0);
            base_atom[a] = w;
            send_word(w);
        end
    endtask

    // One compared frame; with noise, now and then restart the reference mid-frame.
    task automatic send_compared(input int atoms, input logic noise);
        coord_style_t style;
        frd_in_t      w;
        style = coord_style_t'($urandom_range(0, 3));
        for (int a = 0; a < atoms; a++) begin
            w = pack_atom(pick_coord(style, base_atom[a].coord_x),
                          pick_coord(style, base_atom[a].coord_y),
                          pick_coord(style, base_atom[a].coord_z),
                          noise && ($urandom_range(0, 99) < 3));
            send_word(w);
        end
    endtask

    // Raise the count only right before a start-over, so that no unwritten
    // reference entry is ever read.
    task automatic run_episode(input int v, input int frames, input logic noise);
        int atoms;
        atoms = atoms_in(v);
        write_count(v);
        send_reference(atoms);
        repeat (frames) send_compared(atoms, noise);
    endtask

    initial begin
        int episode;
        int pick;
        int v;
        s_valid   <= 1'b0;
        s_word    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= CNT_RESET;
        run_done  <= 1'b0;
        aresetn   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset count of one, first frame after reset without start-over.
        send_word(pack_atom(COORD_MAX, COORD_MIN, '0, 1'b0));
        send_word(pack_atom(COORD_MIN, COORD_MAX, '1, 1'b0));
        send_word(pack_atom(COORD_MAX, COORD_MIN, '0, 1'b0));
        send_word(pack_atom('0, '0, '0, 1'b0));

        // Zero acts as one.
        write_count(0);
        send_word(pack_atom('1, '1, '1, 1'b1));
        send_word(pack_atom(24'sd1, 24'sd2, 24'sd3, 1'b0));

        // Three atoms per frame, then lower the count mid-frame below the position.
        write_count(3);
        send_word(pack_atom(COORD_MAX, '0, COORD_MIN, 1'b1));
        send_word(pack_atom(24'sd65536, -24'sd65536, 24'sd7, 1'b0));
        send_word(pack_atom(COORD_MIN, COORD_MAX, '0, 1'b0));
        send_word(pack_atom(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0));
        send_word(pack_atom(24'sd65537, -24'sd65535, 24'sd9, 1'b0));
        send_word(pack_atom(COORD_MAX, COORD_MIN, '0, 1'b0));
        send_word(pack_atom(COORD_MAX, '0, COORD_MIN, 1'b0));
        send_word(pack_atom('0, '0, '0, 1'b0));
        write_count(1);
        send_word(pack_atom(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));

        // Two atoms: start over in the middle of a compared frame.
        write_count(2);
        send_word(pack_atom(24'sd100, 24'sd200, 24'sd300, 1'b1));
        send_word(pack_atom(-24'sd100, -24'sd200, -24'sd300, 1'b0));
        send_word(pack_atom(24'sd101, 24'sd201, 24'sd301, 1'b0));
        send_word(pack_atom(24'sd5, 24'sd6, 24'sd7, 1'b1));
        send_word(pack_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        send_word(pack_atom(24'sd6, 24'sd6, 24'sd6, 1'b0));
        send_word(pack_atom(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));

        // Back-pressure: block the receiver for a long stretch while one-atom
        // frames keep coming, so the block fills and stalls its input; then
        // pause the sender until everything has drained.
        idle_mode <= IDLE_NONE;
        write_count(1);
        send_reference(1);
        hold_asks <= hold_asks + 1;
        repeat (24) send_compared(1, 1'b0);
        wait_drained();

        // Widest setting: every count bit set, clamped to a full reference store;
        // a one-atom compare right after shows the reference closed at the clamp.
        write_count((1 << CNT_BITS) - 1);
        send_reference(atoms_in((1 << CNT_BITS) - 1));
        write_count(1);
        send_compared(1, 1'b0);

        // Random episodes until the word total is reached: mostly clean frames,
        // some with stray start-overs.
        episode = 0;
        while (words_sent < ITEM_TARGET) begin
            idle_mode <= idle_mode_t'(episode % 4);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                v = $urandom_range(1, 4);
            else if (pick < 80)
                v = $urandom_range(5, 16);
            else if (pick < 95)
                v = $urandom_range(17, 64);
            else
                v = 0;
            run_episode(v, $urandom_range(2, 2 + 40 / atoms_in(v)),
                        $urandom_range(0, 3) == 0);
            episode++;
        end

        // Drain, let any late result show up, then close the books.
        idle_mode <= IDLE_NONE;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        run_done <= 1'b1;
        @(posedge aclk);
        @(posedge aclk);
        $display("Covered %0d input words and %0d RMS results over %0d count settings, %0d cycles",
                 words_sent, results_seen, settings_used, cycles_run);
        $display("Counts spanned zero, reset default, small frames and a full store, with stalls");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
